>>> src/bti_pkg.sv
// shared types, constants and helpers of the bilinear table interpolator
package bti_pkg;

  localparam int FREQ_BITS   = 13;
  localparam int POS_BITS    = 5;
  localparam int FIELD_BITS  = 16;
  localparam int NPTS_BITS   = 6;
  localparam int ADDR_BITS   = 5;
  localparam int DATA_BITS   = 32;

  localparam logic [2:0] REG_F1_LOW  = 3'd0;
  localparam logic [2:0] REG_F1_HIGH = 3'd1;
  localparam logic [2:0] REG_F2_LOW  = 3'd2;
  localparam logic [2:0] REG_F2_HIGH = 3'd3;
  localparam logic [2:0] REG_ROWS    = 3'd4;
  localparam logic [2:0] REG_COLS    = 3'd5;

  localparam logic [FREQ_BITS-1:0] F1_LOW_RST  = 13'd200;
  localparam logic [FREQ_BITS-1:0] F1_HIGH_RST = 13'd1000;
  localparam logic [FREQ_BITS-1:0] F2_LOW_RST  = 13'd500;
  localparam logic [FREQ_BITS-1:0] F2_HIGH_RST = 13'd3000;
  localparam logic [NPTS_BITS-1:0] NPTS_RST    = 6'd32;

  typedef struct packed {
    logic [FREQ_BITS-1:0] f1_low;
    logic [FREQ_BITS-1:0] f1_high;
    logic [FREQ_BITS-1:0] f2_low;
    logic [FREQ_BITS-1:0] f2_high;
    logic [NPTS_BITS-1:0] rows;
    logic [NPTS_BITS-1:0] cols;
  } cfg_t;

  // grid points in use, held to 2..gmax
  function automatic logic [NPTS_BITS:0] clamp_points(logic [NPTS_BITS-1:0] n,
                                                      int unsigned gmax);
    logic [NPTS_BITS:0] r;
    r = {1'b0, n};
    if (n < 6'd2) r = 7'd2;
    else if (32'(n) > gmax) r = 7'(gmax);
    return r;
  endfunction

endpackage

>>> src/bti_ifs.sv
// word channels of the bilinear table interpolator
interface bti_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [4:0]  grid_row;
  logic [4:0]  grid_col;
  logic [15:0] entry_tongue_index;
  logic [15:0] entry_tongue_diameter;
  logic [15:0] entry_lip_opening;
  logic [12:0] first_formant_hz;
  logic [12:0] second_formant_hz;
  modport source (output valid, func, grid_row, grid_col, entry_tongue_index,
                  entry_tongue_diameter, entry_lip_opening, first_formant_hz,
                  second_formant_hz, input ready);
  modport sink (input valid, func, grid_row, grid_col, entry_tongue_index,
                entry_tongue_diameter, entry_lip_opening, first_formant_hz,
                second_formant_hz, output ready);
endinterface

interface bti_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] tongue_index_out;
  logic [15:0] tongue_diameter_out;
  logic [15:0] lip_opening_out;
  modport source (output valid, tongue_index_out, tongue_diameter_out,
                  lip_opening_out, input ready);
  modport sink (input valid, tongue_index_out, tongue_diameter_out,
                lip_opening_out, output ready);
endinterface

>>> src/bti_front.sv
// front end: takes words, clamps frequencies and forms the divider numerators
module bti_front import bti_pkg::*; #(
  parameter int GRID_SIDE_MAX = 32,
  parameter int VALUE_BITS    = 16,
  parameter int ENTRY_BITS    = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bti_in_if.sink                in_ch,
  input  cfg_t                  cfg,
  output logic                  push,
  output logic [ENTRY_BITS-1:0] push_data,
  input  logic                  full
);

  localparam int NB = $clog2(GRID_SIDE_MAX);
  localparam int PW = FREQ_BITS + NB;

  typedef struct packed {
    logic                  lookup;
    logic                  wr_ok;
    logic [NB-1:0]         row;
    logic [NB-1:0]         col;
    logic [3*VALUE_BITS-1:0] data;
    logic [PW-1:0]         p1;
    logic [PW-1:0]         p2;
  } entry_t;

  function automatic logic [FREQ_BITS-1:0] axis_offset(logic [FREQ_BITS-1:0] f,
                                                       logic [FREQ_BITS-1:0] lo,
                                                       logic [FREQ_BITS-1:0] hi);
    logic [FREQ_BITS-1:0] fc;
    fc = f;
    if (fc < lo) fc = lo;
    if (fc > hi) fc = hi;
    return (hi <= lo) ? '0 : fc - lo;
  endfunction

  entry_t        ent_r, ent_nxt;
  logic          vld_r, vld_nxt;
  logic          accept;
  logic [NB-1:0] nm1_r1, nm1_r2;

  assign in_ch.ready = !vld_r || !full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = vld_r;
  assign push_data   = ent_r;

  always_comb begin
    nm1_r1 = NB'(clamp_points(cfg.rows, GRID_SIDE_MAX) - 7'd1);
    nm1_r2 = NB'(clamp_points(cfg.cols, GRID_SIDE_MAX) - 7'd1);
    ent_nxt.lookup = in_ch.func;
    ent_nxt.wr_ok  = (int'(in_ch.grid_row) < GRID_SIDE_MAX) &&
                     (int'(in_ch.grid_col) < GRID_SIDE_MAX);
    ent_nxt.row    = NB'(in_ch.grid_row);
    ent_nxt.col    = NB'(in_ch.grid_col);
    ent_nxt.data   = {VALUE_BITS'(in_ch.entry_tongue_index),
                      VALUE_BITS'(in_ch.entry_tongue_diameter),
                      VALUE_BITS'(in_ch.entry_lip_opening)};
    ent_nxt.p1 = PW'(axis_offset(in_ch.first_formant_hz, cfg.f1_low, cfg.f1_high))
                 * PW'(nm1_r1);
    ent_nxt.p2 = PW'(axis_offset(in_ch.second_formant_hz, cfg.f2_low, cfg.f2_high))
                 * PW'(nm1_r2);
    vld_nxt = vld_r;
    if (accept) vld_nxt = 1'b1;
    else if (!full) vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (accept) ent_r <= ent_nxt;
  end

endmodule

>>> src/bti_fifo.sv
// short word queue between front and back end
module bti_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             pop_vld,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CB = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] buf_r [DEPTH];
  logic [PB-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CB-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CB'(DEPTH));
  assign pop_vld  = (cnt_r != '0);
  assign pop_data = buf_r[rp_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && pop_vld;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) wp_nxt = (wp_r == PB'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (do_pop) rp_nxt = (rp_r == PB'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) buf_r[wp_r] <= push_data;
  end

endmodule

>>> src/bti_back.sv
// back end: pipelined divide, banked grid store and bilinear blend
module bti_back import bti_pkg::*; #(
  parameter int GRID_SIDE_MAX    = 32,
  parameter int VALUE_BITS       = 16,
  parameter int WEIGHT_FRAC_BITS = 12,
  parameter int ENTRY_BITS       = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  pop_vld,
  input  logic [ENTRY_BITS-1:0] pop_data,
  output logic                  pop,
  bti_out_if.source             out_ch
);

  localparam int NB = $clog2(GRID_SIDE_MAX);
  localparam int W  = WEIGHT_FRAC_BITS;
  localparam int VB = VALUE_BITS;
  localparam int Q  = NB + W;
  localparam int PW = FREQ_BITS + NB;
  localparam int HB = (NB > 1) ? NB - 1 : 1;
  localparam int BD = 1 << (2 * HB);
  localparam int KW = 2 * W + 1;
  localparam int SW = VB + KW + 2;
  localparam logic [SW-1:0] RND = SW'(1) << (2 * W - 1);
  localparam logic [W:0]    ONE = (W + 1)'(1) << W;

  typedef struct packed {
    logic          lookup;
    logic          wr_ok;
    logic [NB-1:0] row;
    logic [NB-1:0] col;
    logic [3*VB-1:0] data;
    logic [PW-1:0] p1;
    logic [PW-1:0] p2;
  } entry_t;

  typedef struct packed {
    logic                 vld;
    logic                 lookup;
    logic                 wr_ok;
    logic [NB-1:0]        row;
    logic [NB-1:0]        col;
    logic [3*VB-1:0]      data;
    logic [FREQ_BITS-1:0] rem1;
    logic [FREQ_BITS-1:0] rem2;
    logic [Q-1:0]         q1;
    logic [Q-1:0]         q2;
  } dstage_t;

  typedef struct packed {
    logic            vld;
    logic            lookup;
    logic            wr_ok;
    logic [NB-1:0]   row;
    logic [NB-1:0]   col;
    logic [3*VB-1:0] data;
    logic [W:0]      wu;
    logic [W:0]      wv;
  } cstage_t;

  typedef struct packed {
    logic       vld;
    logic       rp;
    logic       cp;
    logic [W:0] wu;
    logic [W:0] wv;
  } mstage_t;

  // one restoring divide step: shift in the next numerator bit, subtract if it fits
  function automatic logic [FREQ_BITS+Q-1:0] div_step(logic [FREQ_BITS-1:0] rem,
                                                      logic [Q-1:0] q,
                                                      logic [FREQ_BITS-1:0] span);
    logic [FREQ_BITS:0] t;
    logic               b;
    t = {rem, q[Q-1]};
    b = (t >= {1'b0, span});
    if (b) t = t - {1'b0, span};
    return {t[FREQ_BITS-1:0], q[Q-2:0], b};
  endfunction

  entry_t               head;
  dstage_t              d_r [Q+1];
  dstage_t              d_nxt [Q+1];
  cstage_t              c_r, c_nxt;
  mstage_t              m_r;
  logic [3*VB-1:0]      rd_r [4];
  logic [FREQ_BITS-1:0] span1_r, span2_r;
  logic                 en;
  logic                 out_vld_r;
  logic [FIELD_BITS-1:0] out_r [3];

  logic [NB-1:0]  nm1_1, nm1_2, cq1, cq2;
  logic [W:0]     w1, w2;
  logic           empty1, empty2;

  logic                x1_vld_r, x2_vld_r;
  logic [3*VB-1:0]     ca_r, cb_r, cd_r, ce_r;
  logic [KW-1:0]       ka_r, kb_r, kd_r, ke_r;
  logic [3*VB-1:0]     ra0, ra1, rb0, rb1;
  logic [VB+KW-1:0]    pr_r [3][4];

  // whole back end moves together; the output register holds a stalled word
  assign en             = !out_vld_r || out_ch.ready;
  assign pop            = en && pop_vld;
  assign head           = pop_data;
  assign out_ch.valid   = out_vld_r;
  assign out_ch.tongue_index_out    = out_r[2];
  assign out_ch.tongue_diameter_out = out_r[1];
  assign out_ch.lip_opening_out     = out_r[0];

  always_comb begin
    d_nxt[0].vld    = pop_vld;
    d_nxt[0].lookup = head.lookup;
    d_nxt[0].wr_ok  = head.wr_ok;
    d_nxt[0].row    = head.row;
    d_nxt[0].col    = head.col;
    d_nxt[0].data   = head.data;
    d_nxt[0].rem1   = head.p1[PW-1:NB];
    d_nxt[0].rem2   = head.p2[PW-1:NB];
    d_nxt[0].q1     = {head.p1[NB-1:0], {W{1'b0}}};
    d_nxt[0].q2     = {head.p2[NB-1:0], {W{1'b0}}};
    for (int k = 1; k <= Q; k++) begin
      d_nxt[k] = d_r[k-1];
      {d_nxt[k].rem1, d_nxt[k].q1} = div_step(d_r[k-1].rem1, d_r[k-1].q1, span1_r);
      {d_nxt[k].rem2, d_nxt[k].q2} = div_step(d_r[k-1].rem2, d_r[k-1].q2, span2_r);
    end
  end

  // cell index and weight; the top edge falls into the last cell at full weight
  always_comb begin
    nm1_1  = NB'(clamp_points(cfg.rows, GRID_SIDE_MAX) - 7'd1);
    nm1_2  = NB'(clamp_points(cfg.cols, GRID_SIDE_MAX) - 7'd1);
    empty1 = (cfg.f1_high <= cfg.f1_low);
    empty2 = (cfg.f2_high <= cfg.f2_low);
    cq1 = d_r[Q].q1[Q-1:W];
    cq2 = d_r[Q].q2[Q-1:W];
    if (cq1 >= nm1_1) cq1 = nm1_1 - 1'b1;
    if (cq2 >= nm1_2) cq2 = nm1_2 - 1'b1;
    w1 = (W + 1)'(d_r[Q].q1 - {cq1, {W{1'b0}}});
    w2 = (W + 1)'(d_r[Q].q2 - {cq2, {W{1'b0}}});
    if (empty1) begin
      cq1 = '0;
      w1  = '0;
    end
    if (empty2) begin
      cq2 = '0;
      w2  = '0;
    end
    c_nxt.vld    = d_r[Q].vld;
    c_nxt.lookup = d_r[Q].lookup;
    c_nxt.wr_ok  = d_r[Q].wr_ok;
    c_nxt.row    = d_r[Q].lookup ? cq1 : d_r[Q].row;
    c_nxt.col    = d_r[Q].lookup ? cq2 : d_r[Q].col;
    c_nxt.data   = d_r[Q].data;
    c_nxt.wu     = w1;
    c_nxt.wv     = w2;
  end

  always_ff @(posedge clk) begin
    span1_r <= cfg.f1_high - cfg.f1_low;
    span2_r <= cfg.f2_high - cfg.f2_low;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= Q; k++) d_r[k].vld <= 1'b0;
      c_r.vld   <= 1'b0;
      m_r.vld   <= 1'b0;
      x1_vld_r  <= 1'b0;
      x2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      d_r       <= d_nxt;
      c_r       <= c_nxt;
      m_r.vld   <= c_r.vld && c_r.lookup;
      x1_vld_r  <= m_r.vld;
      x2_vld_r  <= x1_vld_r;
      out_vld_r <= x2_vld_r;
    end
    if (en) begin
      m_r.rp <= c_r.row[0];
      m_r.cp <= c_r.col[0];
      m_r.wu <= c_r.wu;
      m_r.wv <= c_r.wv;
    end
  end

  // four banks by row and column parity: the four corners never share a bank
  for (genvar gb = 0; gb < 4; gb++) begin : g_bank
    localparam logic RP = 1'(gb >> 1);
    localparam logic CP = 1'(gb & 1);
    logic [3*VB-1:0] mem [BD];
    logic [NB-1:0]   rrow, rcol;
    logic            we;

    always_comb begin
      rrow = (c_r.row[0] == RP) ? c_r.row : c_r.row + 1'b1;
      rcol = (c_r.col[0] == CP) ? c_r.col : c_r.col + 1'b1;
      we   = en && c_r.vld && !c_r.lookup && c_r.wr_ok &&
             ({c_r.row[0], c_r.col[0]} == 2'(gb));
    end

    always_ff @(posedge clk) begin
      if (we) mem[{HB'(c_r.row >> 1), HB'(c_r.col >> 1)}] <= c_r.data;
      if (en) rd_r[gb] <= mem[{HB'(rrow >> 1), HB'(rcol >> 1)}];
    end
  end

  // put the bank words back in corner order
  always_comb begin
    ra0 = m_r.rp ? rd_r[2] : rd_r[0];
    ra1 = m_r.rp ? rd_r[3] : rd_r[1];
    rb0 = m_r.rp ? rd_r[0] : rd_r[2];
    rb1 = m_r.rp ? rd_r[1] : rd_r[3];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ca_r <= m_r.cp ? ra1 : ra0;
      cd_r <= m_r.cp ? ra0 : ra1;
      cb_r <= m_r.cp ? rb1 : rb0;
      ce_r <= m_r.cp ? rb0 : rb1;
      ka_r <= KW'((2 * W + 2)'(ONE - m_r.wu) * (2 * W + 2)'(ONE - m_r.wv));
      kb_r <= KW'((2 * W + 2)'(m_r.wu) * (2 * W + 2)'(ONE - m_r.wv));
      kd_r <= KW'((2 * W + 2)'(ONE - m_r.wu) * (2 * W + 2)'(m_r.wv));
      ke_r <= KW'((2 * W + 2)'(m_r.wu) * (2 * W + 2)'(m_r.wv));
      for (int j = 0; j < 3; j++) begin
        pr_r[j][0] <= (VB + KW)'(ca_r[j*VB +: VB]) * (VB + KW)'(ka_r);
        pr_r[j][1] <= (VB + KW)'(cb_r[j*VB +: VB]) * (VB + KW)'(kb_r);
        pr_r[j][2] <= (VB + KW)'(cd_r[j*VB +: VB]) * (VB + KW)'(kd_r);
        pr_r[j][3] <= (VB + KW)'(ce_r[j*VB +: VB]) * (VB + KW)'(ke_r);
        out_r[j] <= FIELD_BITS'((SW'(pr_r[j][0]) + SW'(pr_r[j][1]) + SW'(pr_r[j][2])
                                 + SW'(pr_r[j][3]) + RND) >> (2 * W));
      end
    end
  end

endmodule

>>> src/bilinear_table_interpolator.sv
// top level: config registers, front end, word queue and back end
//
//   channel   dir  handshake              carries
//   in_ch     in   valid/ready            grid write or lookup word
//   out_ch    out  valid/ready            three blended values per lookup
//   apb       in   psel/penable, pready=1 six config registers at 4*i
//
// one word per cycle sustained while out_ch is ready; a lookup result reaches out_ch
// through the front register, the word queue, the one-bit-per-stage divider and the
// read and multiply stages behind it. writes give no word.
// synchronous reset clears all control; the grid holds garbage until written.
// a stalled out_ch freezes the back end; the front register and the 4-word queue
// take five more words before in_ch stalls.
module bilinear_table_interpolator import bti_pkg::*; #(
  parameter int GRID_SIDE_MAX    = 32,
  parameter int VALUE_BITS       = 16,
  parameter int WEIGHT_FRAC_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  bti_in_if.sink               in_ch,
  bti_out_if.source            out_ch,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  localparam int NB = $clog2(GRID_SIDE_MAX);
  localparam int EW = 2 + 2 * NB + 3 * VALUE_BITS + 2 * (FREQ_BITS + NB);

  cfg_t          cfg_r, cfg_nxt;
  logic          cfg_we;
  logic          push, full, pop, pop_vld;
  logic [EW-1:0] push_data, pop_data;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (paddr[4:2])
        REG_F1_LOW:  cfg_nxt.f1_low  = pwdata[FREQ_BITS-1:0];
        REG_F1_HIGH: cfg_nxt.f1_high = pwdata[FREQ_BITS-1:0];
        REG_F2_LOW:  cfg_nxt.f2_low  = pwdata[FREQ_BITS-1:0];
        REG_F2_HIGH: cfg_nxt.f2_high = pwdata[FREQ_BITS-1:0];
        REG_ROWS:    cfg_nxt.rows    = pwdata[NPTS_BITS-1:0];
        REG_COLS:    cfg_nxt.cols    = pwdata[NPTS_BITS-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_F1_LOW:  prdata = DATA_BITS'(cfg_r.f1_low);
      REG_F1_HIGH: prdata = DATA_BITS'(cfg_r.f1_high);
      REG_F2_LOW:  prdata = DATA_BITS'(cfg_r.f2_low);
      REG_F2_HIGH: prdata = DATA_BITS'(cfg_r.f2_high);
      REG_ROWS:    prdata = DATA_BITS'(cfg_r.rows);
      REG_COLS:    prdata = DATA_BITS'(cfg_r.cols);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{f1_low: F1_LOW_RST, f1_high: F1_HIGH_RST, f2_low: F2_LOW_RST,
                 f2_high: F2_HIGH_RST, rows: NPTS_RST, cols: NPTS_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bti_front #(
    .GRID_SIDE_MAX(GRID_SIDE_MAX),
    .VALUE_BITS(VALUE_BITS),
    .ENTRY_BITS(EW)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .cfg(cfg_r),
    .push(push),
    .push_data(push_data),
    .full(full)
  );

  bti_fifo #(
    .WIDTH(EW),
    .DEPTH(4)
  ) u_fifo (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .push_data(push_data),
    .full(full),
    .pop(pop),
    .pop_vld(pop_vld),
    .pop_data(pop_data)
  );

  bti_back #(
    .GRID_SIDE_MAX(GRID_SIDE_MAX),
    .VALUE_BITS(VALUE_BITS),
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS),
    .ENTRY_BITS(EW)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .cfg(cfg_r),
    .pop_vld(pop_vld),
    .pop_data(pop_data),
    .pop(pop),
    .out_ch(out_ch)
  );

endmodule

>>> src/bti_checker.sv
// port-level checks of the bilinear table interpolator and their binding
module bti_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_ti,
  input logic [15:0] out_td,
  input logic [15:0] out_lo
);

  // reset empties the pipeline and the queue
  a_out_idle_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word visible right after reset");

  a_in_ready_after_reset: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_ti) && $stable(out_td) && $stable(out_lo))
    else $error("result word changed while stalled");

endmodule

bind bilinear_table_interpolator bti_checker u_bti_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_ti(out_ch.tongue_index_out),
  .out_td(out_ch.tongue_diameter_out),
  .out_lo(out_ch.lip_opening_out)
);
